/* src/lsw_pkg.sv */
// Package for the line stepper with wall stop.
// Sizes, opcodes, register indexes and structs shared by walker, emit and top.
// No dependencies.
`default_nettype none
package lsw_pkg;

  localparam int CELL_SIZE = 16;
  localparam int SCREEN_W  = 1024;
  localparam int SCREEN_H  = 768;
  localparam int MAP_SIDE  = 64;

  localparam int COORD_W   = 10;
  localparam int ERR_W     = 12;
  localparam int CELL_W    = 6;
  localparam int OFFSET_W  = 26;
  localparam int STRIDE_W  = 16;
  localparam int COLOR_W   = 24;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 24;
  localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int MAP_AW    = $clog2(MAP_DEPTH);

  localparam logic [7:0]          ALPHA_OPAQUE = 8'hFF;
  localparam int                  PIX_BYTES    = 4;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd4096;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_MAP   = 2'd2
  } opcode_t;

  typedef enum logic {
    CFG_PIXEL_COLOR = 1'b0,
    CFG_ROW_STRIDE  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               at_target;
    logic               in_map;
  } issue_t;

  typedef struct packed {
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic                on_screen;
    logic [OFFSET_W-1:0] frame_offset;
    logic [DATA_W-1:0]   pixel_data;
    logic [CELL_W-1:0]   map_col;
    logic [CELL_W-1:0]   map_row;
    logic                hit_wall;
    logic                last;
  } result_t;

endpackage
`default_nettype wire

/* src/lsw_ram.sv */
// Generic single-bit-or-wider RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none
module lsw_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/lsw_walker.sv */
// Line state, Bresenham step and wall map access (clearing pass, writes, reads).
// Depends on lsw_pkg and lsw_ram.
`default_nettype none
module lsw_walker
  import lsw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [1:0]         opcode,
  input  wire logic [COORD_W-1:0] start_x,
  input  wire logic [COORD_W-1:0] start_y,
  input  wire logic [COORD_W-1:0] end_x,
  input  wire logic [COORD_W-1:0] end_y,
  input  wire logic [CELL_W-1:0]  cell_col,
  input  wire logic [CELL_W-1:0]  cell_row,
  input  wire logic               cell_is_wall,
  input  wire logic               kill,
  output      logic               clearing,
  output      issue_t             issue,
  output      logic               map_bit
);

  logic [COORD_W-1:0] cur_x, cur_y, target_x, target_y, delta_x, delta_y;
  logic               sign_x, sign_y;
  logic [ERR_W-1:0]   error_term;
  logic               line_active;
  logic [MAP_AW-1:0]  clr_addr;

  logic                   active_eff, start_acc, step_acc, map_acc, at_target, in_map;
  logic [COORD_W-1:0]     col_full, row_full, dx_start, dy_start;
  logic signed [ERR_W:0]  err2, dx_s, dy_s;
  logic                   move_x, move_y;
  logic [ERR_W-1:0]       error_term_next;
  logic                   ram_we, ram_wdata;
  logic [MAP_AW-1:0]      ram_waddr, ram_raddr;

  always_comb begin
    active_eff = line_active && !kill;
    start_acc  = accept && (opcode == OP_START);
    step_acc   = accept && (opcode == OP_STEP) && active_eff;
    map_acc    = accept && (opcode == OP_MAP) && (cell_col < MAP_SIDE) && (cell_row < MAP_SIDE);
    at_target  = (cur_x == target_x) && (cur_y == target_y);
    col_full   = COORD_W'(cur_x / CELL_SIZE);
    row_full   = COORD_W'(cur_y / CELL_SIZE);
    in_map     = (col_full < MAP_SIDE) && (row_full < MAP_SIDE);
    ram_raddr  = MAP_AW'(row_full * MAP_SIDE + col_full);

    dx_start = (end_x > start_x) ? end_x - start_x : start_x - end_x;
    dy_start = (end_y > start_y) ? end_y - start_y : start_y - end_y;

    err2   = {error_term, 1'b0};
    dx_s   = (ERR_W+1)'(delta_x);
    dy_s   = (ERR_W+1)'(delta_y);
    move_x = err2 > -dy_s;
    move_y = err2 < dx_s;
    error_term_next = error_term
                      - (move_x ? ERR_W'(delta_y) : '0)
                      + (move_y ? ERR_W'(delta_x) : '0);

    ram_we    = clearing || map_acc;
    ram_waddr = clearing ? clr_addr : MAP_AW'(cell_row * MAP_SIDE + cell_col);
    ram_wdata = clearing ? 1'b0 : cell_is_wall;

    issue.valid     = step_acc;
    issue.x         = cur_x;
    issue.y         = cur_y;
    issue.at_target = at_target;
    issue.in_map    = in_map;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      clearing    <= 1'b1;
      clr_addr    <= '0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == MAP_AW'(MAP_DEPTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (start_acc) begin
        line_active <= 1'b1;
      end else begin
        line_active <= active_eff && !(step_acc && at_target);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_acc) begin
      cur_x      <= start_x;
      cur_y      <= start_y;
      target_x   <= end_x;
      target_y   <= end_y;
      delta_x    <= dx_start;
      delta_y    <= dy_start;
      sign_x     <= !(start_x < end_x);
      sign_y     <= !(start_y < end_y);
      error_term <= ERR_W'(dx_start) - ERR_W'(dy_start);
    end else if (step_acc) begin
      if (move_x) begin
        cur_x <= sign_x ? cur_x - 1'b1 : cur_x + 1'b1;
      end
      if (move_y) begin
        cur_y <= sign_y ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      error_term <= error_term_next;
    end
  end

  lsw_ram #(
    .WIDTH(1),
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (step_acc && in_map),
    .raddr(ram_raddr),
    .rdata(map_bit)
  );

  a_kill_ends_line: assert property (@(posedge clk) disable iff (rst)
    (kill && !start_acc) |=> !line_active)
    else $error("Line still active after a wall hit.");

  a_no_step_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(step_acc || map_acc))
    else $error("Map accessed during the clearing pass.");

  a_clear_full_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(clearing) |-> ($past(clr_addr) == MAP_AW'(MAP_DEPTH - 1)))
    else $error("Clearing pass ended early.");

endmodule
`default_nettype wire

/* src/lsw_emit.sv */
// Result stage: wall decision, frame offset and colour, and a two-entry result queue.
// Depends on lsw_pkg.
`default_nettype none
module lsw_emit
  import lsw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire issue_t              issue,
  input  wire logic                map_bit,
  input  wire logic [COLOR_W-1:0]  pixel_color,
  input  wire logic [STRIDE_W-1:0] row_stride_bytes,
  output      logic                kill,
  output      logic                room,
  output      logic                res_valid,
  input  wire logic                res_ready,
  output      result_t             res
);

  issue_t  stage;
  result_t queue [2];
  logic    wr_ptr, rd_ptr;
  logic [1:0] count;

  result_t push_data;
  logic    wall, on, push, pop;
  logic [COORD_W+STRIDE_W-1:0] prod;
  logic [2:0] occ;

  always_comb begin
    wall = !stage.in_map || map_bit;
    on   = (stage.x < SCREEN_W) && (stage.y < SCREEN_H);
    prod = (COORD_W+STRIDE_W)'(stage.y) * (COORD_W+STRIDE_W)'(row_stride_bytes);

    push_data.pixel_x      = stage.x;
    push_data.pixel_y      = stage.y;
    push_data.on_screen    = on;
    push_data.frame_offset = on ? OFFSET_W'(prod) + OFFSET_W'(stage.x) * OFFSET_W'(PIX_BYTES)
                                : '0;
    push_data.pixel_data   = on ? {ALPHA_OPAQUE, pixel_color} : '0;
    push_data.map_col      = CELL_W'(stage.x / CELL_SIZE);
    push_data.map_row      = CELL_W'(stage.y / CELL_SIZE);
    push_data.hit_wall     = wall;
    push_data.last         = wall || stage.at_target;

    kill      = stage.valid && wall;
    push      = stage.valid;
    res_valid = (count != 2'd0);
    pop       = res_valid && res_ready;
    res       = queue[rd_ptr];
    occ       = 3'(count) + 3'(stage.valid) - 3'(pop);
    room      = (occ < 3'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= 1'b0;
      rd_ptr      <= 1'b0;
      count       <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= 2'(occ);
    end
  end

  always_ff @(posedge clk) begin
    stage.valid     <= issue.valid && !rst;
    stage.x         <= issue.x;
    stage.y         <= issue.y;
    stage.at_target <= issue.at_target;
    stage.in_map    <= issue.in_map;
    if (push) begin
      queue[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && count == 2'd2) |-> pop)
    else $error("Result queue overflow.");

  a_wall_is_last: assert property (@(posedge clk) disable iff (rst)
    push |-> (!push_data.hit_wall || push_data.last))
    else $error("Wall pixel not marked as the end of the line.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res)))
    else $error("Waiting result item changed before it was taken.");

endmodule
`default_nettype wire

/* src/line_stepper_with_wall_stop_unit.sv */
// Line stepper with wall stop: Bresenham stepping over a 64 x 64 wall map.
// Step results are registered, then queued; one item a cycle is taken while in_ready is high.
// The rate is set by the wall map's single read port, read once per step item.
// After reset the wall map is cleared, one cell a cycle through all 4096 cells, with in_ready low.
// Depends on lsw_pkg, lsw_walker, lsw_emit and lsw_ram.
`default_nettype none
module line_stepper_with_wall_stop_unit
  import lsw_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic [1:0]          opcode,
  input  wire logic [COORD_W-1:0]  start_x,
  input  wire logic [COORD_W-1:0]  start_y,
  input  wire logic [COORD_W-1:0]  end_x,
  input  wire logic [COORD_W-1:0]  end_y,
  input  wire logic [CELL_W-1:0]   cell_col,
  input  wire logic [CELL_W-1:0]   cell_row,
  input  wire logic                cell_is_wall,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [COORD_W-1:0]  pixel_x,
  output      logic [COORD_W-1:0]  pixel_y,
  output      logic                on_screen,
  output      logic [OFFSET_W-1:0] frame_offset,
  output      logic [DATA_W-1:0]   pixel_data,
  output      logic [CELL_W-1:0]   map_col,
  output      logic [CELL_W-1:0]   map_row,
  output      logic                hit_wall,
  output      logic                last,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data
);

  logic [COLOR_W-1:0]  pixel_color;
  logic [STRIDE_W-1:0] row_stride_bytes;

  logic    clearing, room, kill, map_bit, accept;
  issue_t  issue;
  result_t res;

  assign in_ready = !clearing && room;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_color      <= '0;
      row_stride_bytes <= STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_PIXEL_COLOR: pixel_color      <= cfg_data[COLOR_W-1:0];
        CFG_ROW_STRIDE:  row_stride_bytes <= cfg_data[STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lsw_walker u_walker (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .cell_col    (cell_col),
    .cell_row    (cell_row),
    .cell_is_wall(cell_is_wall),
    .kill        (kill),
    .clearing    (clearing),
    .issue       (issue),
    .map_bit     (map_bit)
  );

  lsw_emit u_emit (
    .clk             (clk),
    .rst             (rst),
    .issue           (issue),
    .map_bit         (map_bit),
    .pixel_color     (pixel_color),
    .row_stride_bytes(row_stride_bytes),
    .kill            (kill),
    .room            (room),
    .res_valid       (out_valid),
    .res_ready       (out_ready),
    .res             (res)
  );

  assign pixel_x      = res.pixel_x;
  assign pixel_y      = res.pixel_y;
  assign on_screen    = res.on_screen;
  assign frame_offset = res.frame_offset;
  assign pixel_data   = res.pixel_data;
  assign map_col      = res.map_col;
  assign map_row      = res.map_row;
  assign hit_wall     = res.hit_wall;
  assign last         = res.last;

endmodule
`default_nettype wire
